// ===== sv/asd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Accelerometer step detector package
// Shared payload types, field widths, register indexes and reset values.
// ============================================================================
package asd_pkg;

    localparam int AXIS_W      = 16;
    localparam int SQ_W        = 32;
    localparam int MAG_W       = 16;
    localparam int THR_W       = 16;
    localparam int STRIDE_W    = 12;
    localparam int STEP_OUT_W  = 24;
    localparam int DIST_W      = 36;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE    = 4'd1;

    localparam logic [THR_W-1:0]    THRESHOLD_RESET = 16'd75;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET    = 12'd762;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
    } accel_in_t;

    typedef struct packed {
        logic [STEP_OUT_W-1:0] step_count;
        logic [DIST_W-1:0]     distance_mm;
        logic                  step_event;
        logic [MAG_W-1:0]      magnitude_out;
        logic                  peak_armed;
    } step_out_t;

endpackage

// ===== sv/accel_step_detector_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Accelerometer step detector
// Threshold and peak pedometer: magnitude, sliding window average, step count
// and distance, computed by a small sequencer around shared arithmetic.
// ============================================================================
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    in_data    (accel_in_t)
//  out      out_valid / out_ready  out_data   (step_out_t)
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A result is registered after its transaction passes through the shared
//  squaring multiplier (one axis at a time), the iterative square root and
//  the window, decision and distance steps. A new transaction is accepted
//  only in the idle state, once the previous result has been stored.
//  A result still waiting in the output register holds the block in its
//  distance step. Reset clears the window (through per-entry valid bits).
// ============================================================================
module accel_step_detector_top
    import asd_pkg::*;
#(
    parameter int WINDOW_DEPTH    = 20,
    parameter int STEP_COUNT_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  accel_in_t              in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output step_out_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = MAG_W + $clog2(WINDOW_DEPTH);
    localparam int CMP_W = SUM_W + 1;
    localparam int PRD_W = STEP_COUNT_BITS + STRIDE_W;
    localparam logic [SUM_W-1:0] DEPTH_N  = SUM_W'(WINDOW_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SQUARE = 6'b000010,
        ST_ROOT   = 6'b000100,
        ST_SUM    = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_DIST   = 6'b100000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    accel_in_t                  in_reg;
    logic [1:0]                 sq_cnt_reg;
    logic [SQ_W-1:0]            prod_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic [SUM_W-1:0]           mag_n_reg;
    logic [SUM_W-1:0]           thr_n_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [PTR_W-1:0]           ptr_reg;
    logic [WINDOW_DEPTH-1:0]    ring_valid_reg;
    logic                       armed_reg;
    logic [MAG_W-1:0]           held_peak_reg;
    logic [STEP_COUNT_BITS-1:0] steps_reg;
    logic                       event_reg;
    logic [THR_W-1:0]           threshold_reg;
    logic [STRIDE_W-1:0]        stride_reg;
    step_out_t                  out_reg;
    logic                       out_valid_reg;

    logic signed [AXIS_W-1:0]   op_sel;
    logic signed [SQ_W-1:0]     prod_s;
    logic                       sqrt_start;
    logic [SQ_W-1:0]            sqrt_radicand;
    logic                       sqrt_done;
    logic [MAG_W-1:0]           sqrt_root;
    logic [MAG_W-1:0]           ram_rd_data;
    logic [MAG_W-1:0]           old_mag;
    logic                       rise;
    logic                       fall;
    logic                       out_free;
    logic [PRD_W-1:0]           dist_prod;

    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    op_sel = in_reg.accel_x;
            2'd1:    op_sel = in_reg.accel_y;
            default: op_sel = in_reg.accel_z;
        endcase
    end

    assign prod_s        = SQ_W'(op_sel) * SQ_W'(op_sel);
    assign sqrt_start    = (state_reg == ST_SQUARE) && (sq_cnt_reg == 2'd3);
    assign sqrt_radicand = sq_reg + prod_reg;

    asd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    asd_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (state_reg == ST_DECIDE),
        .wr_addr (ptr_reg),
        .wr_data (mag_reg),
        .rd_addr (ptr_reg),
        .rd_data (ram_rd_data)
    );

    assign old_mag   = ring_valid_reg[ptr_reg] ? ram_rd_data : '0;
    assign rise      = CMP_W'(mag_n_reg) > (CMP_W'(sum_reg) + CMP_W'(thr_n_reg));
    assign fall      = (CMP_W'(mag_n_reg) + CMP_W'(thr_n_reg)) < CMP_W'(sum_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign dist_prod = PRD_W'(steps_reg) * PRD_W'(stride_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (sq_cnt_reg == 2'd3)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:    state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_DIST;
            ST_DIST:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sq_cnt_reg     <= '0;
            ptr_reg        <= '0;
            sum_reg        <= '0;
            ring_valid_reg <= '0;
            armed_reg      <= 1'b0;
            held_peak_reg  <= '0;
            steps_reg      <= '0;
            event_reg      <= 1'b0;
            threshold_reg  <= THRESHOLD_RESET;
            stride_reg     <= STRIDE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                    CFG_STRIDE:    stride_reg    <= cfg_data[STRIDE_W-1:0];
                    default:       ;
                endcase
            end

            if (state_reg == ST_SQUARE)
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            else
            begin
                sq_cnt_reg <= '0;
            end

            if (state_reg == ST_SUM)
            begin
                sum_reg <= sum_reg - SUM_W'(old_mag) + SUM_W'(mag_reg);
            end

            if (state_reg == ST_DECIDE)
            begin
                ring_valid_reg[ptr_reg] <= 1'b1;
                ptr_reg   <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                event_reg <= 1'b0;
                if (rise && !armed_reg && (mag_reg > held_peak_reg))
                begin
                    held_peak_reg <= mag_reg;
                    armed_reg     <= 1'b1;
                end
                else if (fall && armed_reg)
                begin
                    if (steps_reg != '1)
                    begin
                        steps_reg <= steps_reg + 1'b1;
                    end
                    armed_reg     <= 1'b0;
                    held_peak_reg <= '0;
                    event_reg     <= 1'b1;
                end
            end

            if ((state_reg == ST_DIST) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end

        if (state_reg == ST_SQUARE)
        begin
            prod_reg <= SQ_W'(prod_s);
            sq_reg   <= (sq_cnt_reg == 2'd0) ? '0 : sq_reg + prod_reg;
        end

        if ((state_reg == ST_ROOT) && sqrt_done)
        begin
            mag_reg <= sqrt_root;
        end

        if (state_reg == ST_SUM)
        begin
            mag_n_reg <= SUM_W'(mag_reg) * DEPTH_N;
            thr_n_reg <= SUM_W'(threshold_reg) * DEPTH_N;
        end

        if ((state_reg == ST_DIST) && out_free)
        begin
            out_reg.step_count    <= STEP_OUT_W'(steps_reg);
            out_reg.distance_mm   <= DIST_W'(dist_prod);
            out_reg.step_event    <= event_reg;
            out_reg.magnitude_out <= mag_reg;
            out_reg.peak_armed    <= armed_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("Input accepted twice in consecutive cycles");

    a_root_in_place: assert property (
        @(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_ROOT)
    ) else $error("Square root finished outside the root state");

    a_armed_has_peak: assert property (
        @(posedge clk) disable iff (!rst_n)
        armed_reg |-> (held_peak_reg != '0)
    ) else $error("Peak armed with no held peak");

    a_event_disarms: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && fall && armed_reg && !rise) |=> (!armed_reg && event_reg)
    ) else $error("Trough while armed did not count a step");

endmodule

// ===== sv/asd_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
module asd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/asd_isqrt.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Iterative integer square root
// Digit-by-digit floor square root, one result bit per clock cycle.
// ============================================================================
module asd_isqrt
    import asd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SQ_W-1:0]  radicand,
    output logic             done,
    output logic [MAG_W-1:0] root
);

    localparam int CNT_W = $clog2(MAG_W);

    logic [SQ_W-1:0]  rem_reg;
    logic [SQ_W-1:0]  root_reg;
    logic [SQ_W-1:0]  bit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SQ_W-1:0]  trial;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= radicand;
            root_reg <= '0;
            bit_reg  <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[MAG_W-1:0];

endmodule
